// ===== rtl/running_mean_window_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the running mean window unit
// Concurrent checks clocked on clk, with or without reset masking.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_WINDOW_UNIT_DEFINES_SVH
`define RUNNING_MEAN_WINDOW_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is masked while rst_n is low
`define RMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds through reset
`define RMW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMW_ASSERT(lbl, prop, msg)
`define RMW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/rmw_pkg.sv =====
// ----------------------------------------------------------------------------
// rmw_pkg
// Shared constants and the controller to datapath command type.
// ----------------------------------------------------------------------------
package rmw_pkg;

  localparam int WINDOW   = 50;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = $clog2(WINDOW * 65535 + 1);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // one quotient bit per step; the mean always fits the sample width
  localparam int DIV_STEPS  = SAMPLE_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;      // capture sample, read oldest entry
    logic update;    // update window, sum, count and position; seed divider
    logic div_step;  // one restoring division step
    logic out_load;  // move quotient into the output register
  } rmw_cmd_t;

endpackage

// ===== rtl/rmw_datapath.sv =====
// ----------------------------------------------------------------------------
// rmw_datapath
// Sample window memory, running sum, held count, write position and a
// one-bit-per-cycle restoring divider producing the mean.
// ----------------------------------------------------------------------------
`include "running_mean_window_unit_defines.svh"

module rmw_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmw_pkg::rmw_cmd_t             cmd,
  input  logic [rmw_pkg::SAMPLE_W-1:0]  in_sample,
  output logic [rmw_pkg::SAMPLE_W-1:0]  out_mean
);

  localparam int REM_W = rmw_pkg::CNT_W + 1;

  logic [rmw_pkg::SAMPLE_W-1:0] mem [rmw_pkg::WINDOW];
  logic [rmw_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [rmw_pkg::SAMPLE_W-1:0] sample_r;

  logic [rmw_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [rmw_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rmw_pkg::POS_W-1:0]    pos_r, pos_nxt;

  logic [rmw_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [rmw_pkg::SAMPLE_W-1:0] quo_r, quo_nxt;
  logic [rmw_pkg::SAMPLE_W-1:0] mean_r;

  logic                         full;
  logic [rmw_pkg::SUM_W-1:0]    drop;
  logic [REM_W-1:0]             shifted;
  logic [REM_W-1:0]             divisor;

  assign full    = (count_r == rmw_pkg::CNT_W'(rmw_pkg::WINDOW));
  assign drop    = full ? rmw_pkg::SUM_W'(rd_data_r) : '0;
  assign shifted = {rem_r, quo_r[rmw_pkg::SAMPLE_W-1]};
  assign divisor = {1'b0, count_r};

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    if (cmd.update) begin
      sum_nxt = sum_r - drop + rmw_pkg::SUM_W'(sample_r);
      if (!full) begin
        count_nxt = count_r + rmw_pkg::CNT_W'(1);
      end
      if (pos_r == rmw_pkg::POS_W'(rmw_pkg::WINDOW - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + rmw_pkg::POS_W'(1);
      end
      // sum < count * 2^16, so the upper part is already below the divisor
      rem_nxt = rmw_pkg::CNT_W'(sum_nxt >> rmw_pkg::SAMPLE_W);
      quo_nxt = sum_nxt[rmw_pkg::SAMPLE_W-1:0];
    end else if (cmd.div_step) begin
      if (shifted >= divisor) begin
        rem_nxt = rmw_pkg::CNT_W'(shifted - divisor);
        quo_nxt = {quo_r[rmw_pkg::SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[rmw_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[rmw_pkg::SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.out_load) begin
      mean_r <= quo_r;
    end
  end

  // window memory: read the oldest entry on load, overwrite it on update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[pos_r] <= sample_r;
    end
  end

  assign out_mean = mean_r;

  `RMW_ASSERT(a_count_bound, (count_r <= rmw_pkg::CNT_W'(rmw_pkg::WINDOW)), "held count over window")
  `RMW_ASSERT(a_pos_bound, (pos_r <= rmw_pkg::POS_W'(rmw_pkg::WINDOW - 1)), "write position out of range")
  `RMW_ASSERT(a_rem_bound, (cmd.div_step |-> (rem_r < count_r)), "divider remainder not below divisor")

endmodule

// ===== rtl/rmw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmw_ctrl
// Sequencer: accept a beat, update the window, run the divider, hand the
// mean to the output register.
// ----------------------------------------------------------------------------
`include "running_mean_window_unit_defines.svh"

module rmw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rmw_pkg::rmw_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [rmw_pkg::STEP_W-1:0] STEP_LAST = rmw_pkg::STEP_W'(rmw_pkg::DIV_STEPS - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [rmw_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        step_nxt   = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + rmw_pkg::STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RMW_ASSERT(a_no_overwrite, ((out_valid_r && out_stall) |-> !cmd.out_load), "pending mean overwritten")
  `RMW_ASSERT(a_accept_then_update, ((in_valid && !in_stall) |=> cmd.update), "accepted beat not followed by update")
  `RMW_ASSERT(a_div_done, ((cmd.div_step && step_r == STEP_LAST) |=> (state_r == ST_OUT)), "divider did not finish")

endmodule

// ===== rtl/running_mean_window_unit.sv =====
// ----------------------------------------------------------------------------
// running_mean_window_unit
// Moving average over the newest 50 Q8.8 range samples.
// ----------------------------------------------------------------------------
// Every accepted sample beat yields one mean beat, floor(sum / held count),
// with the count growing from 1 to 50 during warm-up. For each item the
// oldest entry is read from the window memory at the accepting edge, the
// update state then updates sum, count and position, the restoring divider
// resolves one quotient bit per cycle, and the output state loads the output
// register once no earlier mean is still held there. The next sample is
// accepted the cycle after that load, even while the previous mean still
// waits to be taken; no new sample is accepted before that load. No clearing
// pass runs after reset: the entry read from the window memory is only used
// once the window is full, so every used entry has been written.
module running_mean_window_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rmw_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rmw_pkg::SAMPLE_W-1:0]  out_mean
);

  rmw_pkg::rmw_cmd_t cmd;

  rmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rmw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_sample),
    .out_mean  (out_mean)
  );

endmodule

// ===== test/tb_running_mean_window_unit.sv =====
// ----------------------------------------------------------------------------
// tb_running_mean_window_unit
// Checks the moving average unit against a predictor of its window and sum.
// Each accepted sample beat updates the predictor, which queues the mean that
// must come back. Mean beats are checked in order. Directed edge samples come
// first, then runs of random, near-maximum, zero-or-one and small samples.
// Both sides idle at random, and the receiver once holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module tb_running_mean_window_unit;

  localparam int WINDOW   = rmw_pkg::WINDOW;
  localparam int SAMPLE_W = rmw_pkg::SAMPLE_W;
  localparam int SUM_W    = rmw_pkg::SUM_W;

  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 40;
  localparam int N_RANDOM   = 500;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_mean;

  running_mean_window_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_mean  (out_mean)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] win_buf [WINDOW];
  logic [SUM_W-1:0]    win_sum = '0;
  int unsigned         win_held = 0;
  int unsigned         win_wpos = 0;

  logic [SAMPLE_W-1:0] sample_q [$];
  logic [SAMPLE_W-1:0] mean_q [$];

  logic in_fire   = 1'b0;
  logic long_hold = 1'b0;
  int   n_samples = 0;
  int   samples_in = 0;
  int   means_out = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   rcv_hold = 0;
  int   rcv_calm = 0;

  // push a sample into the window and return the truncated mean
  function automatic logic [SAMPLE_W-1:0] window_mean(input logic [SAMPLE_W-1:0] s);
    logic [31:0] q;
    if (win_held == WINDOW) begin
      win_sum = win_sum - win_buf[win_wpos];  // oldest entry drops out
    end else begin
      win_held = win_held + 1;
    end
    win_buf[win_wpos] = s;
    win_sum = win_sum + s;
    win_wpos = (win_wpos == WINDOW - 1) ? 0 : win_wpos + 1;
    q = win_sum / win_held;
    return q[SAMPLE_W-1:0];
  endfunction

  // append a sample to the pending stimulus
  function automatic void add_sample(input logic [SAMPLE_W-1:0] s);
    sample_q.insert(sample_q.size(), s);
  endfunction

  // sender
  always @(negedge clk) begin : drive_samples
    int r;
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (sample_q.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q.pop_front();
        r = $urandom_range(0, 99);
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap  <= 0;
        end else if (r < 5) begin
          send_calm <= $urandom_range(10, 30);
          send_gap  <= 0;
        end else if (r < 50) begin
          send_gap <= 0;
        end else if (r < 85) begin
          send_gap <= $urandom_range(1, 3);
        end else if (r < 97) begin
          send_gap <= $urandom_range(4, 24);
        end else begin
          send_gap <= $urandom_range(25, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin : drive_stall
    int r;
    if (rcv_hold > 0) begin
      rcv_hold  <= rcv_hold - 1;
      out_stall <= 1'b1;
    end else if (rcv_calm > 0) begin
      rcv_calm  <= rcv_calm - 1;
      out_stall <= long_hold;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        rcv_calm <= $urandom_range(20, 100);
      end else if (r < 15) begin
        rcv_hold <= $urandom_range(1, 3);
      end else if (r < 19) begin
        rcv_hold <= $urandom_range(4, 20);
      end else if (r == 19) begin
        rcv_hold <= $urandom_range(30, 80);
      end
      out_stall <= long_hold || (r >= 3 && r < 20);
    end
  end

  // long hold-off on the result side so the input backs up
  initial begin : back_pressure
    wait (means_out >= 40);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    long_hold <= 1'b0;
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin : monitor
    logic [SAMPLE_W-1:0] want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mean_q.insert(mean_q.size(), window_mean(in_sample));
        samples_in = samples_in + 1;
      end
      if (out_valid && !out_stall) begin
        means_out = means_out + 1;
        if (mean_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("mean beat %0d with nothing expected: got %h",
                                     means_out, out_mean);
        end else begin
          want = mean_q.pop_front();
          if (out_mean !== want) begin
            errors = errors + 1;
            if (errors <= 10) $display("mean beat %0d: expected %h, got %h",
                                       means_out, want, out_mean);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[running_mean_window_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : main
    int r;
    int len;
    int n_rand;
    // directed: extremes, bit patterns, truncation during warm-up
    add_sample(16'h0000);
    add_sample(16'hFFFF);
    add_sample(16'hFFFF);
    add_sample(16'h0001);
    add_sample(16'hAAAA);
    add_sample(16'h5555);
    add_sample(16'h8000);
    add_sample(16'h7FFF);
    add_sample(16'h0100);
    add_sample(16'h00FF);
    add_sample(16'h0002);
    add_sample(16'h0003);
    add_sample(16'hFFFE);
    add_sample(16'h0000);
    add_sample(16'h1234);
    add_sample(16'hEDCB);
    // random runs; the long ones span more than a full window
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(5, 40);
        repeat (len) add_sample(SAMPLE_W'($urandom_range(0, 65535)));
      end else if (r < 70) begin
        // full window near the top of the range: widest sum
        len = $urandom_range(50, 70);
        repeat (len) add_sample(SAMPLE_W'(65535 - $urandom_range(0, 3)));
      end else if (r < 80) begin
        len = $urandom_range(50, 70);
        repeat (len) add_sample(SAMPLE_W'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) add_sample(SAMPLE_W'($urandom_range(0, 7)));
      end
      n_rand = n_rand + len;
    end
    n_samples = sample_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (samples_in == n_samples);
    wait (mean_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("[running_mean_window_unit] OK");
    end else begin
      $display("[running_mean_window_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rmw_pkg.sv
rtl/rmw_datapath.sv
rtl/rmw_ctrl.sv
rtl/running_mean_window_unit.sv
test/tb_running_mean_window_unit.sv
